@@ hw/rtl/sparse_vector_add_macros.svh @@
// Assertion macros used by the sparse vector adder top level.
`ifndef SPARSE_VECTOR_ADD_MACROS_SVH
`define SPARSE_VECTOR_ADD_MACROS_SVH

`ifndef ASSERT_OFF
`define SVA_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("svadd: property failed");
`define SVA_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("svadd: implication failed");
`define SVA_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("svadd: next-cycle implication failed");
`else
`define SVA_HOLDS(label, clk, rst_n, prop)
`define SVA_IMPLIES(label, clk, rst_n, ante, cons)
`define SVA_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ hw/rtl/svadd_pkg.sv @@
// Shared constants, codes and types of the sparse vector adder.
`default_nettype none
package svadd_pkg;
    localparam int DEPTH      = 32;
    localparam int POS_BITS   = 16;
    localparam int VALUE_BITS = 32;

    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ENTRY_W = VALUE_BITS + POS_BITS;

    localparam logic [1:0] CMD_LOAD_A  = 2'd0;
    localparam logic [1:0] CMD_LOAD_B  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE = 2'd2;

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic        [POS_BITS-1:0]   pos_t;

    typedef struct packed {
        logic   emit;
        logic   adv_a;
        logic   adv_b;
        value_t value;
        pos_t   pos;
    } step_t;
endpackage
`default_nettype wire

@@ hw/rtl/sparse_vector_add.sv @@
// Sparse vector adder top level: list stores, merge sequencer, output register.
//
// Input beats (s_*) carry a command: load into A, load into B, or compute.
// A load writes one (value, position) pair into its list; a load into a
// full list (DEPTH pairs) and the unused command are dropped.
// A compute walks both lists with one shared compare/add unit. Each merge
// step is a list read (ST_FETCH), then compare and add (ST_EVAL), as each
// list store has a single read port. s_ready is low for the whole compute.
// Result beats (m_*) come out in merge order, ascending by position when both
// lists were loaded sorted; one result is held back so that the final one can
// carry m_last. A compute with no results at all gives a single beat with
// m_empty_res high and all else 0. Sums wrap to VALUE_BITS bits. Compute
// clears both lists. A stalled m_ready holds the output register and pauses
// the walk; nothing is lost. Reset (aresetn low at a clock edge) empties both
// lists and the output; stored pairs need no clearing.
`default_nettype none
`include "sparse_vector_add_macros.svh"
module sparse_vector_add (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [1:0]        s_command,
    input  wire svadd_pkg::value_t s_value,
    input  wire svadd_pkg::pos_t   s_position,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output svadd_pkg::value_t      m_out_value,
    output svadd_pkg::pos_t        m_out_position,
    output logic                   m_last,
    output logic                   m_empty_res
);
    import svadd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_EVAL,
        ST_FLUSH
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]   ia_reg, ia_next, ib_reg, ib_next;
    logic               pend_valid_reg, pend_valid_next;
    value_t             pend_value_reg, pend_value_next;
    pos_t               pend_pos_reg, pend_pos_next;
    logic               m_valid_reg, m_valid_next;
    value_t             m_value_reg, m_value_next;
    pos_t               m_pos_reg, m_pos_next;
    logic               m_last_reg, m_last_next;
    logic               m_empty_reg, m_empty_next;

    logic               s_beat, wr_a, wr_b, out_free;
    logic [ENTRY_W-1:0] a_rd, b_rd;
    step_t              step;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_beat   = s_valid && s_ready;
    assign wr_a     = s_beat && (s_command == CMD_LOAD_A) && (cnt_a_reg < CNT_W'(DEPTH));
    assign wr_b     = s_beat && (s_command == CMD_LOAD_B) && (cnt_b_reg < CNT_W'(DEPTH));
    assign out_free = !m_valid_reg || m_ready;

    svadd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_a (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (cnt_a_reg[ADDR_W-1:0]),
        .wr_data ({s_value, s_position}),
        .rd_addr (ia_reg[ADDR_W-1:0]),
        .rd_data (a_rd)
    );

    svadd_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_ram_b (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (cnt_b_reg[ADDR_W-1:0]),
        .wr_data ({s_value, s_position}),
        .rd_addr (ib_reg[ADDR_W-1:0]),
        .rd_data (b_rd)
    );

    svadd_alu u_alu (
        .a_ok  (ia_reg < cnt_a_reg),
        .b_ok  (ib_reg < cnt_b_reg),
        .a_val (a_rd[ENTRY_W-1:POS_BITS]),
        .a_pos (a_rd[POS_BITS-1:0]),
        .b_val (b_rd[ENTRY_W-1:POS_BITS]),
        .b_pos (b_rd[POS_BITS-1:0]),
        .step  (step)
    );

    always_comb begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        ia_next         = ia_reg;
        ib_next         = ib_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_pos_next   = pend_pos_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_pos_next      = m_pos_reg;
        m_last_next     = m_last_reg;
        m_empty_next    = m_empty_reg;

        case (state_reg)
            ST_IDLE: begin
                if (wr_a) begin
                    cnt_a_next = cnt_a_reg + CNT_W'(1);
                end
                if (wr_b) begin
                    cnt_b_next = cnt_b_reg + CNT_W'(1);
                end
                if (s_beat && (s_command == CMD_COMPUTE)) begin
                    ia_next         = '0;
                    ib_next         = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if ((ia_reg == cnt_a_reg) && (ib_reg == cnt_b_reg)) begin
                    state_next = ST_FLUSH;
                end else begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (!(step.emit && pend_valid_reg && !out_free)) begin
                    if (step.emit) begin
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_value_next = pend_value_reg;
                            m_pos_next   = pend_pos_reg;
                            m_last_next  = 1'b0;
                            m_empty_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = step.value;
                        pend_pos_next   = step.pos;
                    end
                    if (step.adv_a) begin
                        ia_next = ia_reg + CNT_W'(1);
                    end
                    if (step.adv_b) begin
                        ib_next = ib_reg + CNT_W'(1);
                    end
                    state_next = ST_FETCH;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_value_next    = pend_valid_reg ? pend_value_reg : '0;
                    m_pos_next      = pend_valid_reg ? pend_pos_reg : '0;
                    m_last_next     = pend_valid_reg;
                    m_empty_next    = !pend_valid_reg;
                    pend_valid_next = 1'b0;
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        ia_reg         <= ia_next;
        ib_reg         <= ib_next;
        pend_value_reg <= pend_value_next;
        pend_pos_reg   <= pend_pos_next;
        m_value_reg    <= m_value_next;
        m_pos_reg      <= m_pos_next;
        m_last_reg     <= m_last_next;
        m_empty_reg    <= m_empty_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_out_value    = m_value_reg;
    assign m_out_position = m_pos_reg;
    assign m_last         = m_last_reg;
    assign m_empty_res    = m_empty_reg;

    `SVA_HOLDS(a_cnt_in_range, aclk, aresetn,
        (cnt_a_reg <= CNT_W'(DEPTH)) && (cnt_b_reg <= CNT_W'(DEPTH)))
    `SVA_IMPLIES(a_empty_beat_clean, aclk, aresetn, m_valid && m_empty_res,
        !m_last && (m_out_value == '0) && (m_out_position == '0))
    `SVA_IMPLIES(a_heads_bounded, aclk, aresetn, state_reg == ST_EVAL,
        (ia_reg <= cnt_a_reg) && (ib_reg <= cnt_b_reg)
        && ((ia_reg != cnt_a_reg) || (ib_reg != cnt_b_reg)))
    `SVA_NEXT(a_flush_clears, aclk, aresetn, (state_reg == ST_FLUSH) && out_free,
        (cnt_a_reg == '0) && (cnt_b_reg == '0) && !pend_valid_reg && m_valid)
endmodule
`default_nettype wire

@@ hw/rtl/svadd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module svadd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/svadd_alu.sv @@
// Shared merge unit: compares the two list heads and forms one merge step.
`default_nettype none
module svadd_alu (
    input  wire logic            a_ok,
    input  wire logic            b_ok,
    input  wire svadd_pkg::value_t a_val,
    input  wire svadd_pkg::pos_t   a_pos,
    input  wire svadd_pkg::value_t b_val,
    input  wire svadd_pkg::pos_t   b_pos,
    output svadd_pkg::step_t     step
);
    import svadd_pkg::*;

    value_t sum;

    assign sum = a_val + b_val;

    always_comb begin
        step = '0;
        if (a_ok && b_ok) begin
            if (a_pos == b_pos) begin
                step.emit  = (sum != '0);
                step.adv_a = 1'b1;
                step.adv_b = 1'b1;
                step.value = sum;
                step.pos   = a_pos;
            end else if (a_pos < b_pos) begin
                step.emit  = 1'b1;
                step.adv_a = 1'b1;
                step.value = a_val;
                step.pos   = a_pos;
            end else begin
                step.emit  = 1'b1;
                step.adv_b = 1'b1;
                step.value = b_val;
                step.pos   = b_pos;
            end
        end else if (a_ok) begin
            step.emit  = 1'b1;
            step.adv_a = 1'b1;
            step.value = a_val;
            step.pos   = a_pos;
        end else if (b_ok) begin
            step.emit  = 1'b1;
            step.adv_b = 1'b1;
            step.value = b_val;
            step.pos   = b_pos;
        end
    end
endmodule
`default_nettype wire

@@ test/sparse_sum_checker.sv @@
// Checker for the sparse vector adder: predicts every merged sum beat and compares results.
module sparse_sum_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire logic [1:0]        s_command,
    input  wire svadd_pkg::value_t s_value,
    input  wire svadd_pkg::pos_t   s_position,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire svadd_pkg::value_t m_out_value,
    input  wire svadd_pkg::pos_t   m_out_position,
    input  wire logic              m_last,
    input  wire logic              m_empty_res,
    output int                     mismatches,
    output int                     sums_pending
);
    import svadd_pkg::*;

    typedef struct packed {
        value_t value;
        pos_t   pos;
        logic   last;
        logic   empty;
    } sum_beat_t;

    value_t    a_val [DEPTH];
    pos_t      a_pos [DEPTH];
    value_t    b_val [DEPTH];
    pos_t      b_pos [DEPTH];
    int        a_count;
    int        b_count;
    sum_beat_t expected_sums [$];

    function automatic sum_beat_t sum_beat(value_t v, pos_t p);
        sum_beat_t beat;
        beat.value = v;
        beat.pos   = p;
        beat.last  = 1'b0;
        beat.empty = 1'b0;
        return beat;
    endfunction

    // two-head walk over both lists; equal positions add, zero sums drop
    function automatic void merge_lists();
        int        ia;
        int        ib;
        int        first;
        value_t    s;
        sum_beat_t beat;
        ia    = 0;
        ib    = 0;
        first = expected_sums.size();
        while (ia < a_count || ib < b_count) begin
            if (ia < a_count && ib < b_count && a_pos[ia] == b_pos[ib]) begin
                s = a_val[ia] + b_val[ib];
                if (s != 0) begin
                    expected_sums.push_back(sum_beat(s, a_pos[ia]));
                end
                ia++;
                ib++;
            end else if (ib >= b_count || (ia < a_count && a_pos[ia] < b_pos[ib])) begin
                expected_sums.push_back(sum_beat(a_val[ia], a_pos[ia]));
                ia++;
            end else begin
                expected_sums.push_back(sum_beat(b_val[ib], b_pos[ib]));
                ib++;
            end
        end
        if (expected_sums.size() == first) begin
            beat       = sum_beat('0, '0);
            beat.empty = 1'b1;
        end else begin
            beat      = expected_sums.pop_back();
            beat.last = 1'b1;
        end
        expected_sums.push_back(beat);
        a_count = 0;
        b_count = 0;
    endfunction

    always @(posedge aclk) begin
        sum_beat_t want;
        sum_beat_t got;
        if (!aresetn) begin
            a_count    = 0;
            b_count    = 0;
            mismatches = 0;
            expected_sums.delete();
        end else begin
            if (s_valid && s_ready) begin
                case (s_command)
                    CMD_LOAD_A: if (a_count < DEPTH) begin
                        a_val[a_count] = s_value;
                        a_pos[a_count] = s_position;
                        a_count++;
                    end
                    CMD_LOAD_B: if (b_count < DEPTH) begin
                        b_val[b_count] = s_value;
                        b_pos[b_count] = s_position;
                        b_count++;
                    end
                    CMD_COMPUTE: begin
                        merge_lists();
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.value = m_out_value;
                got.pos   = m_out_position;
                got.last  = m_last;
                got.empty = m_empty_res;
                if (expected_sums.size() == 0) begin
                    $display("%0t: result beat with none expected: value %0d pos %0d last %b empty %b",
                             $time, got.value, got.pos, got.last, got.empty);
                    mismatches++;
                end else begin
                    want = expected_sums.pop_front();
                    if (got !== want) begin
                        $display("%0t: expected value %0d pos %0d last %b empty %b", $time,
                                 want.value, want.pos, want.last, want.empty);
                        $display("%0t: actual   value %0d pos %0d last %b empty %b", $time,
                                 got.value, got.pos, got.last, got.empty);
                        mismatches++;
                    end
                end
            end
        end
        sums_pending = expected_sums.size();
    end
endmodule

@@ test/tb_top.sv @@
// Testbench top for the sparse vector adder: load and compute beat stimulus, verdict.
module tb_top;
    import svadd_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         ITEM_TARGET = 160;

    typedef struct packed {
        value_t value;
        pos_t   pos;
    } elem_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_ready;
    logic [1:0] s_command  = CMD_LOAD_A;
    value_t     s_value    = '0;
    pos_t       s_position = '0;
    logic       m_valid;
    logic       m_ready    = 1'b0;
    value_t     m_out_value;
    pos_t       m_out_position;
    logic       m_last;
    logic       m_empty_res;

    int    mismatches;
    int    sums_pending;
    int    loaded_a   = 0;
    int    loaded_b   = 0;
    int    items_done = 0;
    logic  s_quiet    = 1'b0;
    logic  m_quiet    = 1'b0;
    elem_t list_a [$];
    elem_t list_b [$];

    sparse_vector_add u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_position (m_out_position),
        .m_last         (m_last),
        .m_empty_res    (m_empty_res)
    );

    sparse_sum_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_value        (s_value),
        .s_position     (s_position),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_value    (m_out_value),
        .m_out_position (m_out_position),
        .m_last         (m_last),
        .m_empty_res    (m_empty_res),
        .mismatches     (mismatches),
        .sums_pending   (sums_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #8000000;
        $display("tb_top: done, errors");
        $finish;
    end

    task automatic send_beat(input logic [1:0] cmd, input value_t val, input pos_t pos);
        int gap;
        gap = s_quiet ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_value    <= val;
        s_position <= pos;
        do @(posedge aclk); while (!s_ready);
        case (cmd)
            CMD_LOAD_A: if (loaded_a < DEPTH) begin
                loaded_a++;
                items_done++;
            end
            CMD_LOAD_B: if (loaded_b < DEPTH) begin
                loaded_b++;
                items_done++;
            end
            CMD_COMPUTE: begin
                loaded_a = 0;
                loaded_b = 0;
                items_done++;
            end
            default: ;
        endcase
    endtask

    function automatic value_t rand_value();
        case ($urandom_range(0, 11))
            0: return {1'b0, {(VALUE_BITS-1){1'b1}}};
            1: return {1'b1, {(VALUE_BITS-1){1'b0}}};
            2: return -1;
            3: return '0;
            default: return value_t'($urandom);
        endcase
    endfunction

    // ascending distinct positions; fill_sel 1 or 2 overfills A or B
    task automatic build_sorted(input int n, input int fill_sel);
        int     p;
        int     which;
        elem_t  e;
        p = $urandom_range(0, 61000);
        for (int i = 0; i < n; i++) begin
            if (fill_sel == 1) begin
                which = ($urandom_range(0, 4) == 0) ? 2 : 0;
            end else if (fill_sel == 2) begin
                which = ($urandom_range(0, 4) == 0) ? 2 : 1;
            end else begin
                which = $urandom_range(0, 2);
            end
            e.value = rand_value();
            e.pos   = pos_t'(p);
            if (which == 1) begin
                list_b.push_back(e);
            end else begin
                list_a.push_back(e);
            end
            if (which == 2) begin
                // a quarter of shared positions cancel out
                e.value = ($urandom_range(0, 3) == 0) ? -e.value : rand_value();
                list_b.push_back(e);
            end
            p += $urandom_range(1, 64);
        end
    endtask

    task automatic flush_lists();
        elem_t e;
        while (list_a.size() + list_b.size() > 0) begin
            if (list_b.size() == 0 || (list_a.size() > 0 && $urandom_range(0, 1) == 1)) begin
                e = list_a.pop_front();
                send_beat(CMD_LOAD_A, e.value, e.pos);
            end else begin
                e = list_b.pop_front();
                send_beat(CMD_LOAD_B, e.value, e.pos);
            end
        end
        send_beat(CMD_COMPUTE, value_t'($urandom), pos_t'($urandom));
    endtask

    task automatic send_noise();
        int         n;
        logic [1:0] cmd;
        n = $urandom_range(1, 10);
        repeat (n) begin
            case ($urandom_range(0, 4))
                0, 1: cmd = CMD_LOAD_A;
                2, 3: cmd = CMD_LOAD_B;
                default: cmd = CMD_UNUSED;
            endcase
            send_beat(cmd, rand_value(), pos_t'($urandom_range(0, 65535)));
        end
        send_beat(CMD_COMPUTE, value_t'($urandom), pos_t'($urandom));
    endtask

    initial begin : result_sink
        int hold;
        int beats;
        hold  = 0;
        beats = 0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                beats++;
                if (beats % 32 == 0) begin
                    m_quiet = ($urandom_range(0, 2) == 0);
                end
                hold = m_quiet ? 0 : $urandom_range(0, 8);
            end
            @(negedge aclk);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int seq;
        int kind;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // both lists empty
        send_beat(CMD_COMPUTE, 32'h7fffffff, 16'hffff);
        send_beat(CMD_UNUSED, 32'h12345678, 16'h0042);
        // wrap to the most negative value; wrap to zero drops the pair
        send_beat(CMD_LOAD_A, 32'h7fffffff, 16'h0000);
        send_beat(CMD_LOAD_B, 32'h00000001, 16'h0000);
        send_beat(CMD_LOAD_A, 32'h80000000, 16'hffff);
        send_beat(CMD_LOAD_B, 32'h80000000, 16'hffff);
        send_beat(CMD_COMPUTE, '0, '0);
        // full cancellation gives the empty beat
        send_beat(CMD_LOAD_A, 5, 16'd7);
        send_beat(CMD_LOAD_B, -5, 16'd7);
        send_beat(CMD_COMPUTE, '0, '0);
        // zero load in one list only
        send_beat(CMD_LOAD_A, 0, 16'd3);
        send_beat(CMD_LOAD_B, -1, 16'd100);
        send_beat(CMD_LOAD_A, 12345, 16'd200);
        send_beat(CMD_COMPUTE, '0, '0);
        // out of order and repeated positions
        send_beat(CMD_LOAD_A, 50, 16'd50);
        send_beat(CMD_LOAD_A, 10, 16'd10);
        send_beat(CMD_LOAD_A, 11, 16'd10);
        send_beat(CMD_LOAD_B, 20, 16'd10);
        send_beat(CMD_LOAD_B, 30, 16'd50);
        send_beat(CMD_COMPUTE, '0, '0);
        // B only
        send_beat(CMD_LOAD_B, -7, 16'd1);
        send_beat(CMD_LOAD_B, 8, 16'd2);
        send_beat(CMD_COMPUTE, '0, '0);

        seq = 0;
        while (items_done < ITEM_TARGET) begin
            s_quiet = ($urandom_range(0, 3) == 0);
            kind = (seq == 2) ? 9 : $urandom_range(0, 9);
            if (kind == 9) begin
                build_sorted(DEPTH + $urandom_range(1, 4), 1 + $urandom_range(0, 1));
                flush_lists();
            end else if (kind < 7) begin
                build_sorted($urandom_range(0, 12), 0);
                flush_lists();
            end else begin
                send_noise();
            end
            seq++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sums_pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end
endmodule

@@ sparse_vector_add.f @@
+incdir+hw/rtl
hw/rtl/svadd_pkg.sv
hw/rtl/svadd_ram.sv
hw/rtl/svadd_alu.sv
hw/rtl/sparse_vector_add.sv
test/sparse_sum_checker.sv
test/tb_top.sv
